/* hdl/hsv2rgb_pkg.sv */
// ----------------------------------------------------------------------------
// HSV to RGB converter package
// Constants, stage record types and the divide-by-255 helper shared by the
// converter pipeline.
// ----------------------------------------------------------------------------
package hsv2rgb_pkg;

   localparam int HueWidth     = 13;
   localparam int ChanWidth    = 8;
   localparam int RemWidth     = 10;

   // One full turn and one sector of hue, in sixteenths of a degree.
   localparam logic [HueWidth-1:0] HueFullTurn = 13'd5760;
   localparam logic [HueWidth-1:0] HueSector   = 13'd960;

   // The sector fraction is rem * 256 / 960 = rem * 4 / 15. It is formed as
   // (rem * 17480) >> 16, which is exact for every rem below 960.
   localparam logic [14:0] FracRecip = 15'd17480;

   localparam logic [ChanWidth-1:0] ChanFull = 8'd255;

   typedef enum logic [2:0] {
      SECTOR_0 = 3'd0,
      SECTOR_1 = 3'd1,
      SECTOR_2 = 3'd2,
      SECTOR_3 = 3'd3,
      SECTOR_4 = 3'd4,
      SECTOR_5 = 3'd5
   } sector_type;

   // After the sector split.
   typedef struct packed {
      sector_type           sector;
      logic [RemWidth-1:0]  rem;
      logic [ChanWidth-1:0] sat;
      logic [ChanWidth-1:0] val;
   } stage_split_type;

   // After the fraction.
   typedef struct packed {
      sector_type           sector;
      logic [ChanWidth-1:0] frac;
      logic [ChanWidth-1:0] sat;
      logic [ChanWidth-1:0] val;
   } stage_frac_type;

   // After the three scale factors.
   typedef struct packed {
      sector_type           sector;
      logic [ChanWidth-1:0] fac_p;
      logic [ChanWidth-1:0] fac_q;
      logic [ChanWidth-1:0] fac_t;
      logic [ChanWidth-1:0] val;
   } stage_factor_type;

   // After the three value products.
   typedef struct packed {
      sector_type               sector;
      logic [2*ChanWidth-1:0]   prod_p;
      logic [2*ChanWidth-1:0]   prod_q;
      logic [2*ChanWidth-1:0]   prod_t;
      logic [ChanWidth-1:0]     val;
   } stage_product_type;

   // Truncating x / 255 for x up to 255 * 255, as ((x+1) + ((x+1) >> 8)) >> 8.
   function automatic logic [ChanWidth-1:0] div_by_255(input logic [2*ChanWidth-1:0] x);
      logic [2*ChanWidth:0] inc;
      logic [2*ChanWidth:0] sum;
      begin
         inc = {1'b0, x} + 17'd1;
         sum = inc + {8'd0, inc[2*ChanWidth:ChanWidth]};
         return sum[2*ChanWidth-1:ChanWidth];
      end
   endfunction

endpackage

/* hdl/hsv_to_rgb_converter.sv */
// ----------------------------------------------------------------------------
// HSV to RGB converter
// Five-stage pixel pipeline that turns hue, saturation and value into 8-bit
// red, green and blue.
// ----------------------------------------------------------------------------
// The converter takes one pixel beat per clock while the output is not
// stalled and returns one RGB beat for each, in order, through the five
// register stages: sector split, fraction, scale factors, value products,
// and divide by 255 with channel select. Throughput is one pixel per cycle
// when not stalled. A stall on the result side freezes every stage at once,
// so req_tready follows rsp_tready while the output register is full. Hue is in
// sixteenths of a degree; a hue of 360 degrees (5760) or above is read as zero.
// Zero saturation gives grey. The block keeps no state between pixels and
// reset only clears the stage valid bits.
module hsv_to_rgb_converter
   import hsv2rgb_pkg::*;
(
   input  logic        clock,
   input  logic        reset,

   input  logic        req_tvalid,
   output logic        req_tready,
   // hue[12:0], saturation[20:13], brightness[28:21], zero fill [31:29]
   input  logic [31:0] req_tdata,

   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // red[7:0], green[15:8], blue[23:16]
   output logic [23:0] rsp_tdata
);

   // All stages advance together whenever the output register can take a beat.
   logic advance;
   assign advance    = !rsp_tvalid || rsp_tready;
   assign req_tready = advance;

   // ---------------------------------------------------------------- stage 1
   // Clamp the hue and split it into sector and remainder within the sector.
   logic [HueWidth-1:0]  hue;
   logic [HueWidth-1:0]  hue_clamped;
   sector_type           sector_in;
   logic [HueWidth-1:0]  base_in;
   stage_split_type      split_in;
   stage_split_type      split_ff;
   logic                 split_valid_ff;

   assign hue         = req_tdata[HueWidth-1:0];
   assign hue_clamped = (hue >= HueFullTurn) ? '0 : hue;

   always_comb begin
      if (hue_clamped >= 5 * HueSector) begin
         sector_in = SECTOR_5;
         base_in   = HueWidth'(5 * HueSector);
      end else if (hue_clamped >= 4 * HueSector) begin
         sector_in = SECTOR_4;
         base_in   = HueWidth'(4 * HueSector);
      end else if (hue_clamped >= 3 * HueSector) begin
         sector_in = SECTOR_3;
         base_in   = HueWidth'(3 * HueSector);
      end else if (hue_clamped >= 2 * HueSector) begin
         sector_in = SECTOR_2;
         base_in   = HueWidth'(2 * HueSector);
      end else if (hue_clamped >= HueSector) begin
         sector_in = SECTOR_1;
         base_in   = HueSector;
      end else begin
         sector_in = SECTOR_0;
         base_in   = '0;
      end
   end

   logic [HueWidth-1:0] rem_full;
   assign rem_full = hue_clamped - base_in;

   always_comb begin
      split_in.sector = sector_in;
      split_in.rem    = rem_full[RemWidth-1:0];
      split_in.sat    = req_tdata[20:13];
      split_in.val    = req_tdata[28:21];
   end

   // ---------------------------------------------------------------- stage 2
   // Fraction within the sector through a reciprocal multiply.
   logic [24:0]     frac_prod;
   stage_frac_type  frac_in;
   stage_frac_type  frac_ff;
   logic            frac_valid_ff;

   assign frac_prod = {15'd0, split_ff.rem} * {10'd0, FracRecip};

   always_comb begin
      frac_in.sector = split_ff.sector;
      frac_in.frac   = frac_prod[23:16];
      frac_in.sat    = split_ff.sat;
      frac_in.val    = split_ff.val;
   end

   // ---------------------------------------------------------------- stage 3
   // Scale factors 255 - s, 255 - (s*f >> 8) and 255 - (s*(256-f) >> 8).
   logic [ChanWidth:0]     frac_inv;
   logic [2*ChanWidth-1:0] sf_prod;
   logic [2*ChanWidth:0]   sfi_prod;
   stage_factor_type       factor_in;
   stage_factor_type       factor_ff;
   logic                   factor_valid_ff;

   assign frac_inv = 9'd256 - {1'b0, frac_ff.frac};
   assign sf_prod  = {8'd0, frac_ff.sat} * {8'd0, frac_ff.frac};
   assign sfi_prod = {9'd0, frac_ff.sat} * {8'd0, frac_inv};

   always_comb begin
      factor_in.sector = frac_ff.sector;
      factor_in.fac_p  = ChanFull - frac_ff.sat;
      factor_in.fac_q  = ChanFull - sf_prod[2*ChanWidth-1:ChanWidth];
      factor_in.fac_t  = ChanFull - sfi_prod[2*ChanWidth-1:ChanWidth];
      factor_in.val    = frac_ff.val;
   end

   // ---------------------------------------------------------------- stage 4
   // Multiply each factor by the value.
   stage_product_type product_in;
   stage_product_type product_ff;
   logic              product_valid_ff;

   always_comb begin
      product_in.sector = factor_ff.sector;
      product_in.prod_p = {8'd0, factor_ff.val} * {8'd0, factor_ff.fac_p};
      product_in.prod_q = {8'd0, factor_ff.val} * {8'd0, factor_ff.fac_q};
      product_in.prod_t = {8'd0, factor_ff.val} * {8'd0, factor_ff.fac_t};
      product_in.val    = factor_ff.val;
   end

   // ---------------------------------------------------------------- stage 5
   // Divide by 255 and route the channels by sector.
   logic [ChanWidth-1:0] p_val;
   logic [ChanWidth-1:0] q_val;
   logic [ChanWidth-1:0] t_val;
   logic [23:0]          rgb_in;
   logic [23:0]          rgb_ff;
   logic                 rgb_valid_ff;

   assign p_val = div_by_255(product_ff.prod_p);
   assign q_val = div_by_255(product_ff.prod_q);
   assign t_val = div_by_255(product_ff.prod_t);

   always_comb begin
      case (product_ff.sector)
         SECTOR_0: rgb_in = {p_val, t_val, product_ff.val};
         SECTOR_1: rgb_in = {p_val, product_ff.val, q_val};
         SECTOR_2: rgb_in = {t_val, product_ff.val, p_val};
         SECTOR_3: rgb_in = {product_ff.val, q_val, p_val};
         SECTOR_4: rgb_in = {product_ff.val, p_val, t_val};
         default:  rgb_in = {q_val, p_val, product_ff.val};
      endcase
   end

   // ---------------------------------------------------------------- registers
   always_ff @(posedge clock) begin
      if (reset) begin
         split_valid_ff   <= 1'b0;
         frac_valid_ff    <= 1'b0;
         factor_valid_ff  <= 1'b0;
         product_valid_ff <= 1'b0;
         rgb_valid_ff     <= 1'b0;
      end else if (advance) begin
         split_valid_ff   <= req_tvalid;
         frac_valid_ff    <= split_valid_ff;
         factor_valid_ff  <= frac_valid_ff;
         product_valid_ff <= factor_valid_ff;
         rgb_valid_ff     <= product_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         split_ff   <= split_in;
         frac_ff    <= frac_in;
         factor_ff  <= factor_in;
         product_ff <= product_in;
         rgb_ff     <= rgb_in;
      end
   end

   assign rsp_tvalid = rgb_valid_ff;
   assign rsp_tdata  = rgb_ff;

   // ---------------------------------------------------------------- assertions
   // The remainder left by the sector split always lies inside one sector.
   assert property (@(posedge clock) disable iff (reset)
      split_valid_ff |-> (split_ff.rem < HueSector[RemWidth-1:0]))
      else $error("sector remainder out of range");

   // The p factor never exceeds the q and t factors.
   assert property (@(posedge clock) disable iff (reset)
      factor_valid_ff |-> (factor_ff.fac_q >= factor_ff.fac_p &&
                           factor_ff.fac_t >= factor_ff.fac_p))
      else $error("scale factor ordering broken");

   // An accepted beat lands in the first stage on the next edge.
   assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> split_valid_ff)
      else $error("accepted beat lost at pipeline entry");

   // A stalled pipeline keeps the valid bits from the split stage through the product stage unchanged.
   assert property (@(posedge clock) disable iff (reset)
      !advance |=> ($stable(split_valid_ff) && $stable(frac_valid_ff) &&
                    $stable(factor_valid_ff) && $stable(product_valid_ff)))
      else $error("pipeline moved during stall");

endmodule

/* tb/hsv_to_rgb_checker.sv */
// ----------------------------------------------------------------------------
// HSV to RGB converter checker
// Watches both streams of the converter, computes the RGB value that each
// accepted pixel must produce, and compares result beats in arrival order.
// ----------------------------------------------------------------------------
module hsv_to_rgb_checker
   import hsv2rgb_pkg::*;
(
   input  logic        clock,
   input  logic        reset,

   input  logic        req_tvalid,
   input  logic        req_tready,
   // hue[12:0], saturation[20:13], brightness[28:21], zero fill [31:29]
   input  logic [31:0] req_tdata,

   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   // red[7:0], green[15:8], blue[23:16]
   input  logic [23:0] rsp_tdata,

   output int          fail_count,
   output int          pending_count
);

   localparam int unsigned FracScale   = 256;
   localparam int          ReportLimit = 10;

   // Red sits in the lowest byte, as on the result stream.
   typedef struct packed {
      logic [ChanWidth-1:0] blue;
      logic [ChanWidth-1:0] green;
      logic [ChanWidth-1:0] red;
   } rgb_type;

   rgb_type expected_rgb[$];
   int      failures = 0;

   assign fail_count = failures;

   initial pending_count = 0;

   function automatic rgb_type rgb_from_hsv(input logic [HueWidth-1:0]  hue,
                                            input logic [ChanWidth-1:0] sat,
                                            input logic [ChanWidth-1:0] val);
      int unsigned h, s, v, rem, frac, p, q, t;
      sector_type  sector;
      rgb_type     pix;
      h = hue;
      s = sat;
      v = val;
      // A full turn or more wraps to red.
      if (h >= HueFullTurn)
         h = 0;
      sector = sector_type'(h / HueSector);
      rem    = h % HueSector;
      frac   = (rem * FracScale) / HueSector;
      p = (v * (ChanFull - s)) / ChanFull;
      q = (v * (ChanFull - ((s * frac) >> 8))) / ChanFull;
      t = (v * (ChanFull - ((s * (FracScale - frac)) >> 8))) / ChanFull;
      case (sector)
         SECTOR_0: begin
            pix.red = ChanWidth'(v); pix.green = ChanWidth'(t); pix.blue = ChanWidth'(p);
         end
         SECTOR_1: begin
            pix.red = ChanWidth'(q); pix.green = ChanWidth'(v); pix.blue = ChanWidth'(p);
         end
         SECTOR_2: begin
            pix.red = ChanWidth'(p); pix.green = ChanWidth'(v); pix.blue = ChanWidth'(t);
         end
         SECTOR_3: begin
            pix.red = ChanWidth'(p); pix.green = ChanWidth'(q); pix.blue = ChanWidth'(v);
         end
         SECTOR_4: begin
            pix.red = ChanWidth'(t); pix.green = ChanWidth'(p); pix.blue = ChanWidth'(v);
         end
         default: begin
            pix.red = ChanWidth'(v); pix.green = ChanWidth'(p); pix.blue = ChanWidth'(q);
         end
      endcase
      return pix;
   endfunction

   always @(posedge clock) begin
      rgb_type got;
      rgb_type want;
      if (!reset) begin
         if (req_tvalid && req_tready)
            expected_rgb.push_back(rgb_from_hsv(req_tdata[HueWidth-1:0],
                                                req_tdata[HueWidth +: ChanWidth],
                                                req_tdata[HueWidth+ChanWidth +: ChanWidth]));
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata;
            if (expected_rgb.size() == 0) begin
               failures++;
               if (failures <= ReportLimit)
                  $display("unexpected result beat: r=%0d g=%0d b=%0d",
                           got.red, got.green, got.blue);
            end else begin
               want = expected_rgb.pop_front();
               if (got.red !== want.red || got.green !== want.green ||
                   got.blue !== want.blue) begin
                  failures++;
                  if (failures <= ReportLimit)
                     $display("mismatch: expected r=%0d g=%0d b=%0d, got r=%0d g=%0d b=%0d",
                              want.red, want.green, want.blue,
                              got.red, got.green, got.blue);
               end
            end
         end
      end
      pending_count <= expected_rgb.size();
   end

endmodule

/* tb/tb_hsv_to_rgb_converter.sv */
// ----------------------------------------------------------------------------
// HSV to RGB converter testbench
// Drives directed and random pixels into the converter under random stalls on
// both streams and reports the verdict from the checker's failure count.
// ----------------------------------------------------------------------------
module tb_hsv_to_rgb_converter;
   import hsv2rgb_pkg::*;

   // Chance, in percent, that either side idles on a given beat or cycle.
   localparam int IdlePercent   = 9;
   localparam int RandomPixels  = 450;
   // The calm window covers these random pixels: neither side idles there.
   localparam int CalmFirst     = 150;
   localparam int CalmLast      = 260;
   // The receiver holds off for a long stretch so that the pipeline fills and
   // the input stream backs up. It starts after the calm window has ended and
   // while the sender still has pixels to offer.
   localparam int HoldOffStart  = 450;
   localparam int HoldOffCycles = 80;
   // Extra cycles after the last result, so that the five-stage pipeline runs dry.
   localparam int DrainCycles   = 20;
   // Cycles without any accepted beat before the run is declared hung.
   localparam int WatchdogLimit = 1000;
   localparam int HueMax        = (1 << HueWidth) - 1;

   logic        clock;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   // hue[12:0], saturation[20:13], brightness[28:21], zero fill [31:29]
   logic [31:0] req_tdata  = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   // red[7:0], green[15:8], blue[23:16]
   logic [23:0] rsp_tdata;
   logic        calm       = 1'b0;
   int          fail_count;
   int          pending_count;

   hsv_to_rgb_converter u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   hsv_to_rgb_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Offers one pixel beat and returns at the edge that accepts it. Valid is
   // only lowered when an idle gap is taken, so back-to-back beats keep it high.
   task automatic send_pixel(input logic [HueWidth-1:0]  hue,
                             input logic [ChanWidth-1:0] sat,
                             input logic [ChanWidth-1:0] val);
      int gap;
      gap = 0;
      if (!calm && $urandom_range(99) < IdlePercent)
         gap = $urandom_range(4, 1);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {3'b000, val, sat, hue};
      do @(posedge clock); while (!req_tready);
   endtask

   // Saturation and value lean toward their extremes now and then, since zero
   // and full scale are where the arithmetic is most likely to slip.
   function automatic logic [ChanWidth-1:0] pick_channel();
      int roll;
      roll = $urandom_range(99);
      if (roll < 10)
         return '0;
      if (roll < 20)
         return ChanFull;
      return ChanWidth'($urandom_range(ChanFull));
   endfunction

   // Stimulus: a directed set first, then random pixels.
   initial begin : stimulus
      logic [HueWidth-1:0]  hue;
      logic [ChanWidth-1:0] sat;
      logic [ChanWidth-1:0] val;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // All-zero and all-ones fields, with the all-ones hue out of range.
      send_pixel(13'd0, 8'd0, 8'd0);
      send_pixel(13'd8191, 8'd255, 8'd255);
      // The boundaries of every sector, mostly at full saturation and value.
      send_pixel(13'd0, 8'd255, 8'd255);
      send_pixel(13'd959, 8'd255, 8'd255);
      send_pixel(13'd960, 8'd255, 8'd255);
      send_pixel(13'd1919, 8'd255, 8'd255);
      send_pixel(13'd1920, 8'd200, 8'd180);
      send_pixel(13'd2880, 8'd255, 8'd255);
      send_pixel(13'd3840, 8'd128, 8'd255);
      send_pixel(13'd4800, 8'd255, 8'd100);
      send_pixel(13'd5759, 8'd255, 8'd255);
      // A full turn and beyond must read as a hue of zero.
      send_pixel(13'd5760, 8'd255, 8'd255);
      send_pixel(13'd6000, 8'd77, 8'd200);
      // Zero saturation gives grey, whatever the hue.
      send_pixel(13'd480, 8'd0, 8'd173);
      send_pixel(13'd2400, 8'd0, 8'd255);
      send_pixel(13'd7000, 8'd0, 8'd90);
      // Zero value gives black.
      send_pixel(13'd3000, 8'd255, 8'd0);
      // Lowest bits set, then alternating bit patterns in every field but the 4095 hue.
      send_pixel(13'd1, 8'd1, 8'd1);
      send_pixel(13'd4095, 8'd170, 8'd85);
      send_pixel(13'd5461, 8'd85, 8'd170);

      // Random pixels, mostly in the valid hue range with some past a turn.
      for (int i = 0; i < RandomPixels; i++) begin
         calm <= (i >= CalmFirst && i < CalmLast);
         if ($urandom_range(99) < 85)
            hue = HueWidth'($urandom_range(HueFullTurn - 1));
         else
            hue = HueWidth'($urandom_range(HueMax, HueFullTurn));
         sat = pick_channel();
         val = pick_channel();
         send_pixel(hue, sat, val);
      end
      req_tvalid <= 1'b0;
      calm       <= 1'b0;

      // Wait for every expected result, then let the pipeline run dry so a
      // stray extra beat would still be caught.
      do @(posedge clock); while (pending_count != 0);
      repeat (DrainCycles) @(posedge clock);
      if (fail_count == 0 && pending_count == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

   // The receiver stalls at random, never in the calm window, and once holds
   // off long enough to back the whole pipeline up into the input stream.
   initial begin : receiver
      int cycle;
      cycle = 0;
      forever begin
         @(posedge clock);
         if (reset) begin
            rsp_tready <= 1'b0;
         end else begin
            cycle++;
            if (cycle >= HoldOffStart && cycle < HoldOffStart + HoldOffCycles)
               rsp_tready <= 1'b0;
            else if (calm)
               rsp_tready <= 1'b1;
            else
               rsp_tready <= ($urandom_range(99) >= IdlePercent);
         end
      end
   end

   // The watchdog ends a hung run: any accepted beat on either stream resets
   // the count of quiet cycles.
   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < WatchdogLimit) begin
         @(posedge clock);
         if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
            quiet = 0;
         else
            quiet++;
      end
      $display("status: fail");
      $finish;
   end

endmodule
